FILE: sv/ccse_pkg.sv
// shared types, constants and register map of the cel shade edge filter
`default_nettype none
package ccse_pkg;

   // parameter defaults
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // operation codes of an input beat
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // luma weights in q16 and the reciprocal of 255 in q32
   localparam logic [23:0] WT_RED     = 24'd19595;
   localparam logic [23:0] WT_GREEN   = 24'd38470;
   localparam logic [23:0] WT_BLUE    = 24'd7471;
   localparam logic [23:0] LUMA_ROUND = 24'd127;
   localparam logic [49:0] LUMA_RECIP = 50'd16843010;
   localparam int          LUMA_W     = 17;
   localparam logic [LUMA_W-1:0] DARK_LUMA = 17'd6;

   // arithmetic unit widths
   localparam int DIV_W  = 40;
   localparam int DIV_CW = $clog2(DIV_W);
   localparam int SQ_W   = 39;
   localparam int MAG_W  = 20;
   localparam int GRAD_W = 21;

   localparam int JOBQ_DEPTH = 4;

   // register map
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_TONE_BANDS,
      REG_POSTERIZE_LEVELS,
      REG_EDGE_LOW,
      REG_EDGE_SPAN,
      REG_LINE_COLOR
   } reg_index_type;

   localparam logic [10:0] RST_IMAGE_WIDTH      = 11'd1024;
   localparam logic [10:0] RST_IMAGE_HEIGHT     = 11'd1024;
   localparam logic [4:0]  RST_TONE_BANDS       = 5'd4;
   localparam logic [4:0]  RST_POSTERIZE_LEVELS = 5'd6;
   localparam logic [18:0] RST_EDGE_LOW         = 19'd22938;
   localparam logic [18:0] RST_EDGE_SPAN        = 19'd5243;
   localparam logic [23:0] RST_LINE_COLOR       = 24'd854548;

   // shading settings handed to the back part
   typedef struct packed {
      logic [4:0]  tone_bands;
      logic [4:0]  posterize_levels;
      logic [18:0] edge_low;
      logic [18:0] edge_span;
      logic [23:0] line_color;
   } cfg_type;

   // one shading job: centre pixel and the lumas of its neighbourhood
   typedef struct packed {
      logic [31:0]       px;
      logic [LUMA_W-1:0] yc;
      logic [LUMA_W-1:0] y_lt;
      logic [LUMA_W-1:0] y_lm;
      logic [LUMA_W-1:0] y_lb;
      logic [LUMA_W-1:0] y_ct;
      logic [LUMA_W-1:0] y_cb;
      logic [LUMA_W-1:0] y_rt;
      logic [LUMA_W-1:0] y_rm;
      logic [LUMA_W-1:0] y_rb;
      logic              last;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SUM,
      F_LUMA,
      F_SHIFT,
      F_EMIT
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_GRAD,
      B_SQR,
      B_ADD,
      B_SQRT,
      B_EDGE,
      B_TDIV,
      B_MUL1,
      B_MUL2,
      B_QDIV,
      B_BL1,
      B_BL2,
      B_ODIV,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

FILE: sv/cartoon_cel_shade_edge_filter_core.sv
// top level of the cel shade edge filter: register file and part wiring
`default_nettype none
// Cel shading filter with sobel outlines on a raster stream of rgba8 pixels.
// Send width*height pixel beats per frame, then width+1 drain beats: results
// come out width+1 beats behind their input, in raster order, and frame_last
// marks the last one. Drain beats sent during the pixel part of a frame are
// swallowed; pixel beats during the drain part count as drain beats. Writing
// width or height restarts the frame. The front takes one beat at a time and
// accepts no new one until it is through: line store read, luma of the new
// window column, window shift and job hand-off, which waits while the job
// queue is full; it feeds a four deep job queue. The back part then works on
// one result at a time: set-up, square root, the edge test, a division when
// the edge ramp needs one, then per channel one division in the shared
// divider for a near black pixel or two otherwise, and the result register,
// which waits until the previous result is taken; the divider sets the rate.
// Line stores are not cleared after reset; entries never written in a frame
// never reach a result.
module cartoon_cel_shade_edge_filter_core import ccse_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input beats
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_alpha_in,
   // result beats
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_alpha_out,
   output logic             rsp_frame_last,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // configuration registers
   logic [10:0] width_ff, height_ff;
   logic [4:0]  bands_ff, levels_ff;
   logic [18:0] low_ff, span_ff;
   logic [23:0] color_ff;

   logic          wr;
   reg_index_type idx;
   logic          restart;
   cfg_type       cfg;

   job_type f_job, q_job;
   logic    f_push, q_full, q_pop, q_empty;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign idx     = reg_index_type'(paddr[4:2]);
   // a new frame size starts the frame over
   assign restart = wr && (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         bands_ff  <= RST_TONE_BANDS;
         levels_ff <= RST_POSTERIZE_LEVELS;
         low_ff    <= RST_EDGE_LOW;
         span_ff   <= RST_EDGE_SPAN;
         color_ff  <= RST_LINE_COLOR;
      end else if (wr) begin
         unique case (idx)
            REG_IMAGE_WIDTH:      width_ff  <= pwdata[10:0];
            REG_IMAGE_HEIGHT:     height_ff <= pwdata[10:0];
            REG_TONE_BANDS:       bands_ff  <= pwdata[4:0];
            REG_POSTERIZE_LEVELS: levels_ff <= pwdata[4:0];
            REG_EDGE_LOW:         low_ff    <= pwdata[18:0];
            REG_EDGE_SPAN:        span_ff   <= pwdata[18:0];
            REG_LINE_COLOR:       color_ff  <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_IMAGE_WIDTH:      prdata = {21'd0, width_ff};
         REG_IMAGE_HEIGHT:     prdata = {21'd0, height_ff};
         REG_TONE_BANDS:       prdata = {27'd0, bands_ff};
         REG_POSTERIZE_LEVELS: prdata = {27'd0, levels_ff};
         REG_EDGE_LOW:         prdata = {13'd0, low_ff};
         REG_EDGE_SPAN:        prdata = {13'd0, span_ff};
         REG_LINE_COLOR:       prdata = {8'd0, color_ff};
         default:              prdata = 32'd0;
      endcase
   end

   assign cfg.tone_bands       = bands_ff;
   assign cfg.posterize_levels = levels_ff;
   assign cfg.edge_low         = low_ff;
   assign cfg.edge_span        = span_ff;
   assign cfg.line_color       = color_ff;

   // front: counters, line stores and window
   ccse_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .push       (push),
      .full       (full),
      .operation  (req_operation),
      .red        (req_red_in),
      .green      (req_green_in),
      .blue       (req_blue_in),
      .alpha      (req_alpha_in),
      .job_full   (q_full),
      .job_push   (f_push),
      .job        (f_job)
   );

   // decoupling queue
   ccse_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_job),
      .empty     (q_empty)
   );

   // back: shading arithmetic and the result register
   ccse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (q_empty),
      .job_pop   (q_pop),
      .job       (q_job),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_red   (rsp_red_out),
      .rsp_green (rsp_green_out),
      .rsp_blue  (rsp_blue_out),
      .rsp_alpha (rsp_alpha_out),
      .rsp_last  (rsp_frame_last)
   );

endmodule
`default_nettype wire

FILE: sv/ccse_front.sv
// front part: raster counters, line stores, 3x3 window and job building
`default_nettype none
module ccse_front import ccse_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic [10:0] width_reg,
   input  wire logic [10:0] height_reg,
   input  wire logic        push,
   output logic             full,
   input  wire logic        operation,
   input  wire logic [7:0]  red,
   input  wire logic [7:0]  green,
   input  wire logic [7:0]  blue,
   input  wire logic [7:0]  alpha,
   input  wire logic        job_full,
   output logic             job_push,
   output job_type          job
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 2);
   localparam int RW = $clog2(MAX_HEIGHT + 2);

   front_state_type state_ff, state_in;

   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic [CW-1:0] col_ff, col_in, drain_ff, drain_in;
   logic [RW-1:0] row_ff, row_in;
   logic          draining, accept, take;
   logic [CW-1:0] cx_sel;
   logic [RW-1:0] cy_sel;

   logic [CW-1:0] cx_ff;
   logic [RW-1:0] cy_ff;
   logic          drn_ff;
   logic [31:0]   n_ff;
   logic [31:0]   rd_a_ff, rd_c_ff;

   logic [31:0] above_mem  [MAX_WIDTH];
   logic [31:0] center_mem [MAX_WIDTH];

   logic [23:0]       s_ff   [3];
   logic [LUMA_W-1:0] col_y_ff [3];
   logic [31:0]       win_px_ff [9];
   logic [LUMA_W-1:0] win_y_ff  [9];

   logic              cx0, emit;
   logic signed [RW+1:0] oy;
   logic [CW-1:0]     ox;
   logic [1:0]        lc, cc, tr, br;
   logic [3:0]        i_lt, i_lm, i_lb, i_ct, i_cm, i_cb, i_rt, i_rm, i_rb;

   function automatic logic [23:0] luma_sum(input logic [31:0] px);
      return WT_RED * {16'd0, px[7:0]} + WT_GREEN * {16'd0, px[15:8]} +
             WT_BLUE * {16'd0, px[23:16]};
   endfunction

   function automatic logic [LUMA_W-1:0] luma_div(input logic [23:0] s);
      logic [49:0] p;
      p = {26'd0, s + LUMA_ROUND} * LUMA_RECIP;
      return p[48:32];
   endfunction

   // clamped frame size
   always_comb begin
      if (width_reg == 11'd0) w_eff = CW'(1);
      else if (int'(width_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_reg);
      if (height_reg == 11'd0) h_eff = RW'(1);
      else if (int'(height_reg) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_reg);
   end

   assign full     = (state_ff != F_IDLE);
   assign accept   = push && !full;
   assign draining = (row_ff >= h_eff);
   assign take     = accept && !(!draining && operation == OP_DRAIN);

   // position of this beat
   always_comb begin
      if (!draining) begin
         cx_sel = col_ff;
         cy_sel = row_ff;
      end else if (drain_ff < w_eff) begin
         cx_sel = drain_ff;
         cy_sel = h_eff;
      end else begin
         cx_sel = '0;
         cy_sel = h_eff + RW'(1);
      end
      if (cx_sel >= w_eff) cx_sel = w_eff - CW'(1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = '0;
      end else if (take) begin
         if (!draining) begin
            col_in = col_ff + CW'(1);
            if (col_in >= w_eff) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end
         end else begin
            drain_in = drain_ff + CW'(1);
            if (drain_in > w_eff) begin
               col_in   = '0;
               row_in   = '0;
               drain_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cx_ff   <= cx_sel;
         cy_ff   <= cy_sel;
         drn_ff  <= draining;
         n_ff    <= draining ? 32'd0 : {alpha, blue, green, red};
         rd_a_ff <= above_mem[cx_sel[AW-1:0]];
         rd_c_ff <= center_mem[cx_sel[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_SUM && !drn_ff) begin
         above_mem[cx_ff[AW-1:0]]  <= rd_c_ff;
         center_mem[cx_ff[AW-1:0]] <= n_ff;
      end
   end

   // luma of the incoming column, sum then scale
   always_ff @(posedge clock) begin
      if (state_ff == F_SUM) begin
         s_ff[0] <= luma_sum(rd_a_ff);
         s_ff[1] <= luma_sum(rd_c_ff);
         s_ff[2] <= luma_sum(n_ff);
      end
      if (state_ff == F_LUMA) begin
         for (int i = 0; i < 3; i++) col_y_ff[i] <= luma_div(s_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_px_ff[i] <= '0;
            win_y_ff[i]  <= '0;
         end
      end else if (state_ff == F_SHIFT) begin
         for (int i = 0; i < 6; i++) begin
            win_px_ff[i] <= win_px_ff[i+3];
            win_y_ff[i]  <= win_y_ff[i+3];
         end
         win_px_ff[6] <= rd_a_ff;
         win_px_ff[7] <= rd_c_ff;
         win_px_ff[8] <= n_ff;
         for (int i = 0; i < 3; i++) win_y_ff[6+i] <= col_y_ff[i];
      end
   end

   // output position and window taps with replicated borders
   always_comb begin
      cx0 = (cx_ff == '0);
      oy  = $signed({2'b00, cy_ff}) - (cx0 ? (RW+2)'(2) : (RW+2)'(1));
      ox  = cx0 ? (w_eff - CW'(1)) : (cx_ff - CW'(1));
      cc  = cx0 ? 2'd2 : 2'd1;
      lc  = cx0 ? 2'd1 : 2'd0;
      if (ox == '0) lc = cc;
      emit = (oy >= 0) && (oy < $signed({2'b00, h_eff}));
      tr = (oy == 0) ? 2'd1 : 2'd0;
      br = (oy == $signed({2'b00, h_eff}) - (RW+2)'(1)) ? 2'd1 : 2'd2;
      i_lt = 4'(lc) * 4'd3 + 4'(tr);
      i_lm = 4'(lc) * 4'd3 + 4'd1;
      i_lb = 4'(lc) * 4'd3 + 4'(br);
      i_ct = 4'(cc) * 4'd3 + 4'(tr);
      i_cm = 4'(cc) * 4'd3 + 4'd1;
      i_cb = 4'(cc) * 4'd3 + 4'(br);
      i_rt = 4'd6 + 4'(tr);
      i_rm = 4'd7;
      i_rb = 4'd6 + 4'(br);
      job.px   = win_px_ff[i_cm];
      job.yc   = win_y_ff[i_cm];
      job.y_lt = win_y_ff[i_lt];
      job.y_lm = win_y_ff[i_lm];
      job.y_lb = win_y_ff[i_lb];
      job.y_ct = win_y_ff[i_ct];
      job.y_cb = win_y_ff[i_cb];
      job.y_rt = win_y_ff[i_rt];
      job.y_rm = win_y_ff[i_rm];
      job.y_rb = win_y_ff[i_rb];
      job.last = (ox == w_eff - CW'(1)) && (oy == $signed({2'b00, h_eff}) - (RW+2)'(1));
   end

   always_comb begin
      state_in = state_ff;
      job_push = 1'b0;
      unique case (state_ff)
         F_IDLE:  if (take) state_in = F_SUM;
         F_SUM:   state_in = F_LUMA;
         F_LUMA:  state_in = cx0 ? F_EMIT : F_SHIFT;
         F_SHIFT: state_in = cx0 ? F_IDLE : F_EMIT;
         F_EMIT: begin
            if (!emit || !job_full) begin
               job_push = emit;
               state_in = cx0 ? F_SHIFT : F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/ccse_job_queue.sv
// short job queue between the front and back parts
`default_nettype none
module ccse_job_queue import ccse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         empty
);

   localparam int PW = $clog2(JOBQ_DEPTH);

   job_type       slot_ff [JOBQ_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;
   logic          do_push, do_pop;

   assign full     = (cnt_ff == (PW+1)'(JOBQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + PW'(1);
         if (do_pop) rd_ff <= rd_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: sv/ccse_divider.sv
// restoring divider, one quotient bit a cycle
`default_nettype none
module ccse_divider import ccse_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   input  wire logic [DIV_W-1:0] den,
   output logic                  done,
   output logic [DIV_W-1:0]      quot
);

   logic              busy_ff, done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DIV_W-1:0]  nsh_ff, rem_ff, den_ff, quot_ff;
   logic [DIV_W:0]    r2, diff;
   logic              ge;

   assign r2   = {rem_ff, nsh_ff[DIV_W-1]};
   assign diff = r2 - {1'b0, den_ff};
   assign ge   = (r2 >= {1'b0, den_ff});
   assign done = done_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) busy_ff <= 1'b1;
         else if (busy_ff && cnt_ff == '0) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= DIV_CW'(DIV_W - 1);
         nsh_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - DIV_CW'(1);
         nsh_ff  <= {nsh_ff[DIV_W-2:0], 1'b0};
         rem_ff  <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
         quot_ff <= {quot_ff[DIV_W-2:0], ge};
      end
   end

endmodule
`default_nettype wire

FILE: sv/ccse_isqrt.sv
// integer square root, one result bit a cycle
`default_nettype none
module ccse_isqrt import ccse_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [SQ_W-1:0] value,
   output logic                 done,
   output logic [MAG_W-1:0]     root
);

   logic            busy_ff, done_ff;
   logic [SQ_W-1:0] v_ff, res_ff, bit_ff, trial;
   logic            ge;

   assign trial = res_ff + bit_ff;
   assign ge    = (v_ff >= trial);
   assign done  = done_ff;
   assign root  = res_ff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && bit_ff[0];
         if (start) busy_ff <= 1'b1;
         else if (busy_ff && bit_ff[0]) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << (SQ_W - 1);
      end else if (busy_ff) begin
         if (ge) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ccse_back.sv
// back part: sobel magnitude, edge ramp, cel scaling, posterize and blend
`default_nettype none
module ccse_back import ccse_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        job_empty,
   output logic             job_pop,
   input  job_type          job,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last
);

   // reciprocal of 255 in q24, rounded up
   localparam logic [28:0] RECIP_255 = 29'd65794;

   back_state_type state_ff, state_in;

   job_type                   job_ff;
   logic signed [GRAD_W-1:0]  gx_ff, gy_ff, gx_in, gy_in;
   logic [4:0]                k_ff;
   logic [21:0]               yb;
   logic [SQ_W-2:0]           sqx_ff, sqy_ff;
   logic signed [2*GRAD_W-1:0] px2, py2;
   logic [MAG_W-1:0]          mag_ff, root;
   logic [16:0]               t16_ff;
   logic [1:0]                ch_ff;
   logic [12:0]               ck_ff, cl_ff;
   logic [21:0]               dy_ff;
   logic [4:0]                q_ff;
   logic [29:0]               a_ff;
   logic [24:0]               b_ff;
   logic [7:0]                chan_ff [3];
   logic                      out_valid_ff;

   logic [4:0]       div_eff, lev, c_unused;
   logic [18:0]      span;
   logic [7:0]       c, lb;
   logic [MAG_W-1:0] low, diff;
   logic             sq_start, sq_done, div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, quot, num40, den40;
   logic [17:0]      nk;
   logic [12:0]      q255;
   logic             load_out;
   logic [12:0]      dk_y;
   logic [28:0]      dk_p;
   logic [4:0]       dark_q;

   assign div_eff = (cfg.tone_bands > 5'd1) ? cfg.tone_bands - 5'd1 : 5'd1;
   assign lev     = (cfg.posterize_levels != 5'd0) ? cfg.posterize_levels : 5'd1;
   assign span    = (cfg.edge_span != 19'd0) ? cfg.edge_span : 19'd1;
   assign low     = {1'b0, cfg.edge_low};
   assign diff    = mag_ff - low;
   assign c_unused = '0;

   // channel bytes: red low in the pixel, high in the line colour
   always_comb begin
      case (ch_ff)
         2'd0:    begin c = job_ff.px[7:0];   lb = cfg.line_color[23:16]; end
         2'd1:    begin c = job_ff.px[15:8];  lb = cfg.line_color[15:8];  end
         default: begin c = job_ff.px[23:16]; lb = cfg.line_color[7:0];   end
      endcase
   end

   always_comb begin
      gx_in = - $signed({4'd0, job_ff.y_lt}) - ($signed({4'd0, job_ff.y_lm}) <<< 1)
              - $signed({4'd0, job_ff.y_lb}) + $signed({4'd0, job_ff.y_rt})
              + ($signed({4'd0, job_ff.y_rm}) <<< 1) + $signed({4'd0, job_ff.y_rb});
      gy_in = - $signed({4'd0, job_ff.y_lt}) - ($signed({4'd0, job_ff.y_ct}) <<< 1)
              - $signed({4'd0, job_ff.y_rt}) + $signed({4'd0, job_ff.y_lb})
              + ($signed({4'd0, job_ff.y_cb}) <<< 1) + $signed({4'd0, job_ff.y_rb});
      yb  = {5'd0, job_ff.yc} * {17'd0, cfg.tone_bands};
      px2 = gx_ff * gx_ff;
      py2 = gy_ff * gy_ff;
      nk    = {5'd0, ck_ff} * {13'd0, lev};
      num40 = {6'd0, nk, 16'd0};
      den40 = DIV_W'({dy_ff, 8'd0}) - DIV_W'(dy_ff);
      q255  = {q_ff, 8'd0} - {8'd0, q_ff};
      // near black: round(c*lev/255) by reciprocal multiplication
      dk_y   = cl_ff + 13'd127;
      dk_p   = {16'd0, dk_y} * RECIP_255;
      dark_q = dk_p[28:24];
   end

   ccse_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (SQ_W'(sqx_ff) + SQ_W'(sqy_ff)),
      .done  (sq_done),
      .root  (root)
   );

   ccse_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      state_in  = state_ff;
      job_pop   = 1'b0;
      sq_start  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DIV_W'(1);
      load_out  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               state_in = B_GRAD;
            end
         end
         B_GRAD: state_in = B_SQR;
         B_SQR:  state_in = B_ADD;
         B_ADD: begin
            sq_start = 1'b1;
            state_in = B_SQRT;
         end
         B_SQRT: if (sq_done) state_in = B_EDGE;
         B_EDGE: begin
            if (mag_ff <= low || diff >= {1'b0, span}) begin
               state_in = B_MUL1;
            end else begin
               div_start = 1'b1;
               div_num   = DIV_W'({diff, 16'd0});
               div_den   = DIV_W'(span);
               state_in  = B_TDIV;
            end
         end
         B_TDIV: if (div_done) state_in = B_MUL1;
         B_MUL1: state_in = B_MUL2;
         B_MUL2: begin
            if (job_ff.yc <= DARK_LUMA) begin
               state_in = B_BL1;
            end else begin
               div_start = 1'b1;
               div_num   = (num40 << 1) + den40;
               div_den   = den40 << 1;
               state_in  = B_QDIV;
            end
         end
         B_QDIV: if (div_done) state_in = B_BL1;
         B_BL1:  state_in = B_BL2;
         B_BL2: begin
            div_start = 1'b1;
            div_num   = DIV_W'(a_ff) + DIV_W'({5'd0, b_ff} * {25'd0, lev}) +
                        DIV_W'({lev, 15'd0});
            div_den   = DIV_W'({lev, 16'd0});
            state_in  = B_ODIV;
         end
         B_ODIV: if (div_done) state_in = (ch_ff == 2'd2) ? B_OUT : B_MUL1;
         B_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job;
      if (state_ff == B_GRAD) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         k_ff  <= yb[20:16] | c_unused;
      end
      if (state_ff == B_SQR) begin
         sqx_ff <= px2[SQ_W-2:0];
         sqy_ff <= py2[SQ_W-2:0];
      end
      if (state_ff == B_SQRT && sq_done) mag_ff <= root;
      if (state_ff == B_EDGE) begin
         ch_ff <= 2'd0;
         if (mag_ff <= low) t16_ff <= 17'd0;
         else if (diff >= {1'b0, span}) t16_ff <= 17'd65536;
      end
      if (state_ff == B_TDIV && div_done) t16_ff <= quot[16:0];
      if (state_ff == B_MUL1) begin
         ck_ff <= {5'd0, c} * {8'd0, k_ff};
         cl_ff <= {5'd0, c} * {8'd0, lev};
         dy_ff <= {17'd0, div_eff} * {5'd0, job_ff.yc};
      end
      if (state_ff == B_MUL2 && job_ff.yc <= DARK_LUMA) begin
         q_ff <= (dark_q > lev) ? lev : dark_q;
      end
      if (state_ff == B_QDIV && div_done) begin
         q_ff <= (quot > DIV_W'(lev)) ? lev : quot[4:0];
      end
      if (state_ff == B_BL1) begin
         a_ff <= {17'd0, q255} * (30'd65536 - {13'd0, t16_ff});
         b_ff <= {17'd0, lb} * {8'd0, t16_ff};
      end
      if (state_ff == B_ODIV && div_done) begin
         chan_ff[ch_ff] <= quot[7:0];
         ch_ff          <= ch_ff + 2'd1;
      end
      if (load_out) begin
         rsp_red   <= chan_ff[0];
         rsp_green <= chan_ff[1];
         rsp_blue  <= chan_ff[2];
         rsp_alpha <= job_ff.px[31:24];
         rsp_last  <= job_ff.last;
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule
`default_nettype wire

FILE: sv/ccse_checker.sv
// port level checks of the cel shade edge filter and their bind
`default_nettype none
module ccse_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       req_operation,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_red_out,
   input wire logic [7:0] rsp_green_out,
   input wire logic [7:0] rsp_blue_out,
   input wire logic [7:0] rsp_alpha_out,
   input wire logic       rsp_frame_last
);

   // out of reset nothing waits and the input side is open
   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("not idle after reset");

   // a pixel beat always occupies the front for its next cycle
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !req_operation) |=> full)
      else $error("front open right after a pixel beat");

   // a waiting result beat holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_red_out) && $stable(rsp_green_out) &&
      $stable(rsp_blue_out) && $stable(rsp_alpha_out) && $stable(rsp_frame_last)))
      else $error("waiting result beat changed");

endmodule

bind cartoon_cel_shade_edge_filter_core ccse_checker u_ccse_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .req_operation  (req_operation),
   .empty          (empty),
   .pop            (pop),
   .rsp_red_out    (rsp_red_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_alpha_out  (rsp_alpha_out),
   .rsp_frame_last (rsp_frame_last)
);
`default_nettype wire

FILE: verif/cartoon_cel_shade_edge_filter_checker.sv
// checker of the cel shade edge filter: pixel predictor and result scoreboard
`default_nettype none
module cartoon_cel_shade_edge_filter_checker import ccse_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_alpha_in,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [7:0]  rsp_red_out,
   input  wire logic [7:0]  rsp_green_out,
   input  wire logic [7:0]  rsp_blue_out,
   input  wire logic [7:0]  rsp_alpha_out,
   input  wire logic        rsp_frame_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } shaded_pixel_t;

   shaded_pixel_t shaded_q[$];

   logic [10:0] width_r, height_r;
   logic [4:0]  bands_r, levels_r;
   logic [18:0] edge_low_r, edge_span_r;
   logic [23:0] line_r;
   logic [31:0] above_mem [1024];
   logic [31:0] centre_mem [1024];
   logic [31:0] win [9];
   int unsigned col_cnt, row_cnt, drain_cnt;
   int          errors;

   function automatic longint unsigned luma_of(logic [31:0] px);
      longint unsigned s;
      s = 19595 * px[7:0] + 38470 * px[15:8] + 7471 * px[23:16];
      return (s + 127) / 255;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint wl(int col, int row);
      return longint'(luma_of(win[col * 3 + row]));
   endfunction

   function automatic shaded_pixel_t shade_pixel(int lc, int cc, int rc, int tr, int mr,
                                                 int br, bit last);
      shaded_pixel_t    o;
      logic [31:0]      px;
      longint unsigned  y16, bands, dv, lev, span, k, mag, t16, c, lb, q, x, num, den;
      longint           gx, gy;
      logic [7:0]       chan [3];
      px    = win[cc * 3 + mr];
      y16   = luma_of(px);
      bands = bands_r;
      dv    = bands > 1 ? bands - 1 : 1;
      lev   = levels_r != 0 ? levels_r : 1;
      span  = edge_span_r != 0 ? edge_span_r : 1;
      k     = (y16 * bands) >> 16;
      gx = -wl(lc, tr) - 2 * wl(lc, mr) - wl(lc, br) + wl(rc, tr) + 2 * wl(rc, mr) + wl(rc, br);
      gy = -wl(lc, tr) - 2 * wl(cc, tr) - wl(rc, tr) + wl(lc, br) + 2 * wl(cc, br) + wl(rc, br);
      mag = int_sqrt(longint'(gx * gx) + longint'(gy * gy));
      if (mag <= edge_low_r) t16 = 0;
      else if (mag - edge_low_r >= span) t16 = 65536;
      else t16 = ((mag - edge_low_r) * 65536) / span;
      for (int ch = 0; ch < 3; ch++) begin
         c  = (px >> (8 * ch)) & 8'hff;
         lb = (line_r >> (16 - 8 * ch)) & 8'hff;
         if (y16 > DARK_LUMA) begin
            num = c * k * lev * 65536;
            den = 255 * dv * y16;
            q = (2 * num + den) / (2 * den);
         end else begin
            q = (2 * c * lev + 255) / 510;
         end
         if (q > lev) q = lev;
         x = q * 255 * (65536 - t16) + lb * t16 * lev;
         chan[ch] = 8'((x + 32768 * lev) / (65536 * lev));
      end
      o.red   = chan[0];
      o.green = chan[1];
      o.blue  = chan[2];
      o.alpha = px[31:24];
      o.last  = last;
      return o;
   endfunction

   task automatic shift_window(logic [31:0] a, logic [31:0] c, logic [31:0] n);
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = a;
      win[7] = c;
      win[8] = n;
   endtask

   // advance the raster position by one accepted beat and queue its pixel if any
   task automatic raster_step(logic op, logic [31:0] pixel);
      int unsigned w, h, cx, cy, ox;
      int          oy, lc, cc, rc, tr, mr, br;
      bit          draining;
      logic [31:0] a, c, n;
      w = width_r < 1 ? 1 : (width_r > 1024 ? 1024 : width_r);
      h = height_r < 1 ? 1 : (height_r > 1024 ? 1024 : height_r);
      draining = row_cnt >= h;
      n = '0;
      if (!draining && op == OP_DRAIN) return;
      if (!draining) begin
         cx = col_cnt;
         cy = row_cnt;
      end else if (drain_cnt < w) begin
         cx = drain_cnt;
         cy = h;
      end else begin
         cx = 0;
         cy = h + 1;
      end
      if (cx >= w) cx = w - 1;
      a = above_mem[cx];
      c = centre_mem[cx];
      if (!draining) begin
         n = pixel;
         above_mem[cx]  = c;
         centre_mem[cx] = n;
      end
      if (cx == 0) begin
         ox = w - 1;
         oy = int'(cy) - 2;
         lc = 1; cc = 2; rc = 2;
         if (ox == 0) lc = 2;
      end else begin
         shift_window(a, c, n);
         ox = cx - 1;
         oy = int'(cy) - 1;
         lc = 0; cc = 1; rc = 2;
         if (ox == 0) lc = 1;
      end
      if (oy >= 0 && oy < int'(h)) begin
         tr = 0; mr = 1; br = 2;
         if (oy == 0) tr = 1;
         if (oy == int'(h) - 1) br = 1;
         shaded_q.push_back(shade_pixel(lc, cc, rc, tr, mr, br,
                                        ox == w - 1 && oy == int'(h) - 1));
      end
      if (cx == 0) shift_window(a, c, n);
      if (!draining) begin
         col_cnt++;
         if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
         end
      end else begin
         drain_cnt++;
         if (drain_cnt > w) begin
            col_cnt = 0; row_cnt = 0; drain_cnt = 0;
         end
      end
   endtask

   task automatic write_setting(int idx, logic [31:0] v);
      case (idx)
         REG_IMAGE_WIDTH:      width_r     = v[10:0];
         REG_IMAGE_HEIGHT:     height_r    = v[10:0];
         REG_TONE_BANDS:       bands_r     = v[4:0];
         REG_POSTERIZE_LEVELS: levels_r    = v[4:0];
         REG_EDGE_LOW:         edge_low_r  = v[18:0];
         REG_EDGE_SPAN:        edge_span_r = v[18:0];
         REG_LINE_COLOR:       line_r      = v[23:0];
         default: ;
      endcase
      if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
         col_cnt = 0; row_cnt = 0; drain_cnt = 0;
      end
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   initial begin
      errors = 0;
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      shaded_pixel_t want;
      if (reset) begin
         width_r = RST_IMAGE_WIDTH;
         height_r = RST_IMAGE_HEIGHT;
         bands_r = RST_TONE_BANDS;
         levels_r = RST_POSTERIZE_LEVELS;
         edge_low_r = RST_EDGE_LOW;
         edge_span_r = RST_EDGE_SPAN;
         line_r = RST_LINE_COLOR;
         for (int i = 0; i < 1024; i++) begin
            above_mem[i] = '0;
            centre_mem[i] = '0;
         end
         for (int i = 0; i < 9; i++) win[i] = '0;
         col_cnt = 0; row_cnt = 0; drain_cnt = 0;
         shaded_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) write_setting(int'(paddr >> 2), pwdata);
         if (pop && !empty) begin
            if (shaded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0d %0d",
                        $time, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out,
                        rsp_frame_last);
            end else begin
               want = shaded_q.pop_front();
               check_field("red", want.red, rsp_red_out);
               check_field("green", want.green, rsp_green_out);
               check_field("blue", want.blue, rsp_blue_out);
               check_field("alpha", want.alpha, rsp_alpha_out);
               check_field("frame_last", 8'(want.last), 8'(rsp_frame_last));
            end
         end
         if (push && !full)
            raster_step(req_operation, {req_alpha_in, req_blue_in, req_green_in, req_red_in});
      end
      fail_count <= errors;
      pending <= shaded_q.size();
   end
endmodule
`default_nettype wire

FILE: verif/cartoon_cel_shade_edge_filter_core_tb.sv
// testbench top of the cel shade edge filter: stimulus, register writes and verdict
`default_nettype none
module cartoon_cel_shade_edge_filter_core_tb import ccse_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        req_operation = OP_PIXEL;
   logic [7:0]  req_red_in = '0, req_green_in = '0, req_blue_in = '0, req_alpha_in = '0;
   logic        pop = 1'b0;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic        full, empty, rsp_frame_last, pready;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic [31:0] prdata;
   int          fail_count, pending;
   int          beats_sent;
   int          style;          // pixel content style of the current frame
   logic [7:0]  flat_lo, flat_hi;

   cartoon_cel_shade_edge_filter_core dut (
      .clock, .reset, .push, .full, .req_operation, .req_red_in, .req_green_in,
      .req_blue_in, .req_alpha_in, .empty, .pop, .rsp_red_out, .rsp_green_out,
      .rsp_blue_out, .rsp_alpha_out, .rsp_frame_last, .psel, .penable, .pwrite,
      .paddr, .pwdata, .prdata, .pready
   );

   cartoon_cel_shade_edge_filter_checker checker_i (
      .clock, .reset, .push, .full, .req_operation, .req_red_in, .req_green_in,
      .req_blue_in, .req_alpha_in, .empty, .pop, .rsp_red_out, .rsp_green_out,
      .rsp_blue_out, .rsp_alpha_out, .rsp_frame_last, .psel, .penable, .pwrite,
      .paddr, .pwdata, .pready, .fail_count, .pending
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one input beat, after a random gap; push stays high across back to back beats
   task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a);
      int gap;
      gap = $urandom_range(3);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= op;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_alpha_in <= a;
      do @(posedge clock); while (full);
      beats_sent++;
   endtask

   // register write: setup cycle then access cycle
   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 5'(4 * int'(idx));
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // hold off until every queued pixel is out and the back part has gone quiet
   task automatic wait_idle();
      push <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_shading(logic [4:0] bands, logic [4:0] levels, logic [18:0] lo,
                              logic [18:0] span, logic [23:0] line);
      write_reg(REG_TONE_BANDS, bands);
      write_reg(REG_POSTERIZE_LEVELS, levels);
      write_reg(REG_EDGE_LOW, lo);
      write_reg(REG_EDGE_SPAN, span);
      write_reg(REG_LINE_COLOR, line);
   endtask

   function automatic logic [7:0] pick_byte();
      case (style)
         0: return 8'($urandom);
         1: return $urandom_range(1) ? flat_hi : flat_lo;
         2: return $urandom_range(1) ? 8'hff : 8'h00;
         default: return 8'($urandom_range(8));   // near black; only all-zero pixels take the dark luma path
      endcase
   endfunction

   // one whole frame: pixels with odd swallowed drain beats, then the drain part
   task automatic run_frame(int w, int h, int noise_pct);
      logic [7:0] r, g, b;
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         r = pick_byte();
         g = (style == 1 && $urandom_range(3) != 0) ? r : pick_byte();
         b = (style == 1 && $urandom_range(3) != 0) ? r : pick_byte();
         send_beat(OP_PIXEL, r, g, b, 8'($urandom));
      end
      // pixel beats here only count as drain beats
      for (int i = 0; i <= w; i++)
         send_beat($urandom_range(99) < noise_pct ? OP_PIXEL : OP_DRAIN,
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   function automatic logic [18:0] pick_edge();
      case ($urandom_range(5))
         0: return 19'd0;
         1: return 19'd371000;
         2: return 19'h7ffff;
         3: return 19'($urandom_range(300000));
         default: return 19'($urandom_range(60000));
      endcase
   endfunction

   function automatic logic [4:0] pick_small(logic [4:0] top_val);
      case ($urandom_range(5))
         0: return 5'd0;
         1: return 5'd1;
         2: return top_val;
         3: return 5'h1f;
         default: return 5'($urandom_range(16));
      endcase
   endfunction

   // receiver: random pop gaps, plus one long hold-off so the block backs up
   initial begin
      int gap, popped;
      popped = 0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(3);
         if (popped == 40) gap = 3000;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         popped++;
      end
   end

   // run limit
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int w, h, wr, hr;
      bit big_done;
      beats_sent = 0;
      big_done = 0;
      style = 0;
      flat_lo = 8'd20;
      flat_hi = 8'd230;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single pixel frame with default shading, swallowed and counted noise
      write_reg(REG_IMAGE_WIDTH, 1);
      write_reg(REG_IMAGE_HEIGHT, 1);
      send_beat(OP_DRAIN, 8'h12, 8'h34, 8'h56, 8'h78);
      send_beat(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
      send_beat(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // directed: hard edges, white line, extremes and a dark pixel
      set_shading(5'd16, 5'd16, 19'd0, 19'd1, 24'hffffff);
      write_reg(REG_IMAGE_WIDTH, 3);
      write_reg(REG_IMAGE_HEIGHT, 2);
      send_beat(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_beat(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
      send_beat(OP_PIXEL, 8'h05, 8'h01, 8'h02, 8'h80);
      send_beat(OP_PIXEL, 8'hff, 8'h00, 8'h00, 8'h01);
      send_beat(OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'hfe);
      send_beat(OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h7f);
      for (int i = 0; i < 4; i++) send_beat(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // directed: width write part way through a frame restarts it
      set_shading(5'd1, 5'd1, 19'h7ffff, 19'h7ffff, 24'h000000);
      write_reg(REG_IMAGE_WIDTH, 4);
      write_reg(REG_IMAGE_HEIGHT, 4);
      for (int i = 0; i < 6; i++)
         send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 2);
      write_reg(REG_IMAGE_HEIGHT, 2);
      run_frame(2, 2, 0);
      wait_idle();

      // random frames, mostly small, one long row
      while (beats_sent < 900) begin
         if (!big_done && beats_sent > 300) begin
            w = 256; h = 1; wr = 256; hr = 1;
            big_done = 1;
         end else begin
            w = $urandom_range(8);
            h = $urandom_range(6);
            wr = w; hr = h;
            // out of range sizes are clamped by the block
            if (w == 0) begin
               wr = $urandom_range(1) ? 0 : 2047;
               w = wr == 0 ? 1 : 1024;
               if (w == 1024) begin
                  wr = 0; w = 1;
               end
            end
            if (h == 0) begin
               hr = 0; h = 1;
            end
         end
         style = $urandom_range(3);
         flat_lo = 8'($urandom);
         flat_hi = 8'($urandom);
         set_shading(pick_small(5'd16), pick_small(5'd16), pick_edge(),
                     $urandom_range(4) == 0 ? 19'd1 : pick_edge(),
                     $urandom_range(3) == 0 ? 24'(($urandom_range(1)) ? 24'hffffff : 0)
                                            : 24'($urandom));
         write_reg(REG_IMAGE_WIDTH, wr);
         write_reg(REG_IMAGE_HEIGHT, hr);
         run_frame(w, h, 5);
         // some frames follow straight on without reconfiguring
         if ($urandom_range(2) == 0) begin
            run_frame(w, h, 5);
         end
         wait_idle();
      end

      push <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
